>>> hdl/assert_macros.svh
// assertion helpers for the list block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// check an expression at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/pil_pkg.sv
`default_nettype none

package pil_pkg;

  // list geometry
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int POS_W  = 5;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  // stream packing
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DISPLAY = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             rotate;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/pil_cell.sv
`default_nettype none

module pil_cell (
  input  wire                      clk,
  input  pil_pkg::cell_ctrl_t      ctrl,
  input  wire [pil_pkg::IDX_W-1:0] cell_idx,
  input  pil_pkg::data_t           left_val,
  input  pil_pkg::data_t           right_val,
  input  pil_pkg::data_t           head_val,
  input  pil_pkg::data_t           ins_val,
  output pil_pkg::data_t           val
);

  pil_pkg::data_t                val_r;
  pil_pkg::data_t                val_nxt;
  logic [pil_pkg::CNT_W-1:0]     idx_ext;
  logic [pil_pkg::CNT_W-1:0]     idx_inc;

  assign idx_ext = pil_pkg::CNT_W'(cell_idx);
  assign idx_inc = idx_ext + pil_pkg::CNT_W'(1);

  // pick this cell's next value from itself, a neighbor, the head cell or the insert value
  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift_up) begin
      if (idx_ext == ctrl.pos) begin
        val_nxt = ins_val;
      end else if (idx_ext > ctrl.pos && idx_ext <= ctrl.count) begin
        val_nxt = left_val;
      end
    end else if (ctrl.shift_down) begin
      if (idx_ext >= ctrl.pos && idx_inc < ctrl.count) begin
        val_nxt = right_val;
      end
    end else if (ctrl.rotate) begin
      if (idx_inc < ctrl.count) begin
        val_nxt = right_val;
      end else if (idx_inc == ctrl.count) begin
        val_nxt = head_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

>>> hdl/positional_insert_delete_list.sv
`default_nettype none

// Bounded ordered list of up to 16 signed 32-bit items, kept in a row of cells
// that shift together. Insert, delete and clear take one transaction in and give
// one result back; the block accepts an item in the same cycle that the previous
// result is taken, so these run at one item per cycle. Display emits one result
// per stored item, cell 0 each cycle while the row rotates one place; after the
// accepting cycle it gives one result per cycle while the output is taken, and
// it leaves the order unchanged; an empty list gives a single empty-status
// result. Every input's final result carries tlast. Stored values need no clearing
// after reset: only cells below the count are ever read.
module positional_insert_delete_list (
  input  wire                               clk,
  input  wire                               rst_n,
  // in: [1:0] action
  input  wire [pil_pkg::ACT_W-1:0]          in_tuser,
  // in: [4:0] position, [36:5] item_value, [39:37] zero
  input  wire [pil_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // out: [1:0] status, [33:2] value, [37:34] index, [42:38] count, [47:43] zero
  output logic [pil_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  wire                               out_tready
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DISP = 1'b1;

  // input fields
  logic [pil_pkg::ACT_W-1:0]   act;
  logic [pil_pkg::POS_W-1:0]   pos;
  pil_pkg::data_t              ival;

  assign act  = in_tuser;
  assign pos  = in_tdata[pil_pkg::POS_W-1:0];
  assign ival = in_tdata[pil_pkg::POS_W +: pil_pkg::DATA_W];

  // control state
  logic                        state_r, state_nxt;
  logic [pil_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [pil_pkg::IDX_W-1:0]   disp_idx_r, disp_idx_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [pil_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  pil_pkg::data_t              out_value_r, out_value_nxt;
  logic [pil_pkg::IDX_W-1:0]   out_index_r, out_index_nxt;
  logic [pil_pkg::CNT_W-1:0]   out_count_r, out_count_nxt;
  logic                        out_last_r, out_last_nxt;

  // cell row
  pil_pkg::data_t              cell_val [pil_pkg::DEPTH];
  pil_pkg::cell_ctrl_t         cell_ctrl;

  // per-transaction decode
  logic                        in_fire;
  logic                        out_free;
  logic                        disp_fire;
  logic                        disp_last;
  logic                        ins_ok;
  logic                        del_ok;
  logic                        start_disp;
  logic [pil_pkg::STAT_W-1:0]  res_status;
  pil_pkg::data_t              res_value;
  logic [pil_pkg::IDX_W-1:0]   res_index;
  logic [pil_pkg::CNT_W-1:0]   res_count;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign disp_fire = (state_r == S_DISP) && out_free;
  assign disp_last = (pil_pkg::CNT_W'(disp_idx_r) + pil_pkg::CNT_W'(1)) == count_r;

  // evaluate one action against the current count
  always_comb begin
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    start_disp = 1'b0;
    res_status = pil_pkg::STAT_OK;
    res_value  = '0;
    res_index  = '0;
    res_count  = count_r;
    unique case (act)
      pil_pkg::ACT_INSERT: begin
        if (count_r == pil_pkg::CNT_W'(pil_pkg::DEPTH)) begin
          res_status = pil_pkg::STAT_FULL;
        end else if (pos > count_r) begin
          res_status = pil_pkg::STAT_BADPOS;
        end else begin
          ins_ok    = 1'b1;
          res_count = count_r + pil_pkg::CNT_W'(1);
        end
      end
      pil_pkg::ACT_DELETE: begin
        if (count_r == '0) begin
          res_status = pil_pkg::STAT_EMPTY;
        end else if (pos >= count_r) begin
          res_status = pil_pkg::STAT_BADPOS;
        end else begin
          del_ok    = 1'b1;
          res_value = cell_val[pos[pil_pkg::IDX_W-1:0]];
          res_index = pos[pil_pkg::IDX_W-1:0];
          res_count = count_r - pil_pkg::CNT_W'(1);
        end
      end
      pil_pkg::ACT_DISPLAY: begin
        if (count_r == '0) begin
          res_status = pil_pkg::STAT_EMPTY;
        end else begin
          start_disp = 1'b1;
        end
      end
      pil_pkg::ACT_CLEAR: begin
        res_count = '0;
      end
      default: begin
        res_status = pil_pkg::STAT_OK;
      end
    endcase
  end

  // command to the cell row
  assign cell_ctrl.shift_up   = in_fire && ins_ok;
  assign cell_ctrl.shift_down = in_fire && del_ok;
  assign cell_ctrl.rotate     = disp_fire;
  assign cell_ctrl.pos        = pos;
  assign cell_ctrl.count      = count_r;

  // row of cells, each wired to its neighbors
  for (genvar i = 0; i < pil_pkg::DEPTH; i++) begin : g_cell
    pil_pkg::data_t left_v;
    pil_pkg::data_t right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == pil_pkg::DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    pil_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .cell_idx  (pil_pkg::IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .ins_val   (ival),
      .val       (cell_val[i])
    );
  end

  // sequencer and output register next state
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    disp_idx_nxt   = disp_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    if (in_fire) begin
      count_nxt = res_count;
      if (start_disp) begin
        state_nxt    = S_DISP;
        disp_idx_nxt = '0;
      end else begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status;
        out_value_nxt  = res_value;
        out_index_nxt  = res_index;
        out_count_nxt  = res_count;
        out_last_nxt   = 1'b1;
      end
    end else if (disp_fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pil_pkg::STAT_OK;
      out_value_nxt  = cell_val[0];
      out_index_nxt  = disp_idx_r;
      out_count_nxt  = count_r;
      out_last_nxt   = disp_last;
      disp_idx_nxt   = disp_idx_r + pil_pkg::IDX_W'(1);
      if (disp_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      disp_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      disp_idx_r  <= disp_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_count_r, out_index_r, out_value_r, out_status_r};

  // checks
  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, count_r <= pil_pkg::CNT_W'(pil_pkg::DEPTH), "count over depth")
  `ASSERT_IMPLIES(a_disp_nonempty, state_r == S_DISP, count_r != '0, "display of empty list")
  `ASSERT_IMPLIES(a_disp_idx, state_r == S_DISP, pil_pkg::CNT_W'(disp_idx_r) < count_r, "display index past count")
  `ASSERT_NEXT(a_ins_count, in_fire && ins_ok, count_r == $past(count_r) + pil_pkg::CNT_W'(1), "insert did not grow count")

endmodule

`default_nettype wire

>>> dv/pil_list_checker.sv
`timescale 1ns / 100ps

// watches both streams of the list block, keeps a shadow copy of the list
// and compares every result transaction against the expected one
module pil_list_checker
  import pil_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire [ACT_W-1:0]        in_tuser,
  input  wire [IN_DATA_W-1:0]    in_tdata,
  input  wire                    in_tvalid,
  input  wire                    in_tready,
  input  wire [OUT_DATA_W-1:0]   out_tdata,
  input  wire                    out_tlast,
  input  wire                    out_tvalid,
  input  wire                    out_tready,
  output int                     fail_cnt,
  output int                     pending_cnt,
  output int                     checked_cnt
);

  // result field offsets inside out_tdata
  localparam int VAL_LSB = STAT_W;
  localparam int IDX_LSB = VAL_LSB + DATA_W;
  localparam int CNT_LSB = IDX_LSB + IDX_W;
  localparam int PAD_LSB = CNT_LSB + CNT_W;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    data_t             value;
    logic [IDX_W-1:0]  index;
    logic [CNT_W-1:0]  count;
    logic              last;
  } list_result_t;

  // shadow list contents
  data_t        list_cells [DEPTH];
  int           list_len;
  list_result_t expected_results [$];
  int           mismatches;
  int           results_seen;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic push_result(input logic [STAT_W-1:0] status, input data_t value,
                             input int index, input int count, input logic last);
    list_result_t r;
    r.status = status;
    r.value  = value;
    r.index  = IDX_W'(index);
    r.count  = CNT_W'(count);
    r.last   = last;
    expected_results.push_back(r);
  endtask

  // update the shadow list for one accepted action and queue its results
  task automatic apply_action(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                              input data_t val);
    int    i;
    data_t removed;
    case (act)
      ACT_INSERT: begin
        if (list_len >= DEPTH) begin
          push_result(STAT_FULL, '0, 0, list_len, 1'b1);
        end else if (pos > list_len) begin
          push_result(STAT_BADPOS, '0, 0, list_len, 1'b1);
        end else begin
          for (i = list_len; i > pos; i--)
            list_cells[i] = list_cells[i-1];
          list_cells[pos[IDX_W-1:0]] = val;
          list_len++;
          push_result(STAT_OK, '0, 0, list_len, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (list_len == 0) begin
          push_result(STAT_EMPTY, '0, 0, list_len, 1'b1);
        end else if (pos >= list_len) begin
          push_result(STAT_BADPOS, '0, 0, list_len, 1'b1);
        end else begin
          removed = list_cells[pos[IDX_W-1:0]];
          for (i = int'(pos); i < list_len - 1; i++)
            list_cells[i] = list_cells[i+1];
          list_len--;
          push_result(STAT_OK, removed, int'(pos), list_len, 1'b1);
        end
      end
      ACT_DISPLAY: begin
        if (list_len == 0) begin
          push_result(STAT_EMPTY, '0, 0, 0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++)
            push_result(STAT_OK, list_cells[i], i, list_len, i == list_len - 1);
        end
      end
      default: begin
        list_len = 0;
        push_result(STAT_OK, '0, 0, 0, 1'b1);
      end
    endcase
  endtask

  // results first, so a result never meets an expectation queued at the same edge
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_tdata), 64'(0));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[STAT_W-1:0] !== want.status)
            report_mismatch("status", 64'(out_tdata[STAT_W-1:0]), 64'(want.status));
          if (out_tdata[VAL_LSB +: DATA_W] !== want.value)
            report_mismatch("value", 64'(out_tdata[VAL_LSB +: DATA_W]),
                            64'(unsigned'(want.value)));
          if (out_tdata[IDX_LSB +: IDX_W] !== want.index)
            report_mismatch("index", 64'(out_tdata[IDX_LSB +: IDX_W]), 64'(want.index));
          if (out_tdata[CNT_LSB +: CNT_W] !== want.count)
            report_mismatch("count", 64'(out_tdata[CNT_LSB +: CNT_W]), 64'(want.count));
          if (out_tlast !== want.last)
            report_mismatch("last", 64'(out_tlast), 64'(want.last));
          if (out_tdata[OUT_DATA_W-1:PAD_LSB] !== '0)
            report_mismatch("padding", 64'(out_tdata[OUT_DATA_W-1:PAD_LSB]), 64'(0));
        end
      end
      if (in_tvalid && in_tready)
        apply_action(in_tuser, in_tdata[POS_W-1:0], in_tdata[POS_W +: DATA_W]);
    end
    fail_cnt    <= mismatches;
    pending_cnt <= expected_results.size();
    checked_cnt <= results_seen;
  end

endmodule

>>> dv/tb_positional_insert_delete_list.sv
`timescale 1ns / 100ps

module tb_positional_insert_delete_list;
  import pil_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic [ACT_W-1:0]      in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  wire                   in_tready;
  wire [OUT_DATA_W-1:0]  out_tdata;
  wire                   out_tlast;
  wire                   out_tvalid;
  logic                  out_tready;

  int tx_idle_pct;
  int rx_idle_pct;
  int occupancy;
  int sent;
  int fail_cnt;
  int pending_cnt;
  int checked_cnt;

  positional_insert_delete_list i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  pil_list_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .checked_cnt (checked_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // one action transaction, with random idle cycles ahead of it
  task automatic send_action(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                             input data_t val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tuser  <= act;
    in_tdata  <= {{(IN_DATA_W-POS_W-DATA_W){1'b0}}, val, pos};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
    // rough fill level, to steer the random actions and the fill loop
    case (act)
      ACT_INSERT: if (occupancy < DEPTH && pos <= occupancy) occupancy++;
      ACT_DELETE: if (pos < occupancy) occupancy--;
      ACT_CLEAR:  occupancy = 0;
      default: ;
    endcase
  endtask

  // mostly valid positions, insert-heavy so the list often runs full
  task automatic send_random;
    int                pick;
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    data_t             val;
    pick = $urandom_range(0, 99);
    if (pick < 55)      act = ACT_INSERT;
    else if (pick < 80) act = ACT_DELETE;
    else if (pick < 95) act = ACT_DISPLAY;
    else                act = ACT_CLEAR;
    if ($urandom_range(0, 9) < 8) begin
      if (act == ACT_DELETE && occupancy > 0) pos = POS_W'($urandom_range(0, occupancy - 1));
      else pos = POS_W'($urandom_range(0, occupancy));
    end else begin
      pos = POS_W'($urandom_range(0, 31));
    end
    case ($urandom_range(0, 7))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7fff_ffff;
      default: val = $urandom();
    endcase
    send_action(act, pos, val);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tuser    = '0;
    in_tdata    = '0;
    in_tvalid   = 1'b0;
    out_tready  = 1'b0;
    tx_idle_pct = 14;
    rx_idle_pct = 80;
    occupancy   = 0;
    sent        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corners
    send_action(ACT_CLEAR, 5'd0, 32'sd0);
    send_action(ACT_DISPLAY, 5'd0, 32'sd0);
    send_action(ACT_DELETE, 5'd0, 32'sd0);
    send_action(ACT_INSERT, 5'd1, 32'sd5);
    // front, append and middle inserts with extreme values
    send_action(ACT_INSERT, 5'd0, 32'h8000_0000);
    send_action(ACT_INSERT, 5'd1, 32'h7fff_ffff);
    send_action(ACT_INSERT, 5'd0, 32'hffff_ffff);
    send_action(ACT_INSERT, 5'd1, 32'h0000_0000);
    // positions past the end
    send_action(ACT_INSERT, 5'd31, 32'h1234_5678);
    send_action(ACT_DELETE, 5'd31, 32'sd0);
    send_action(ACT_DELETE, 5'd4, 32'sd0);
    send_action(ACT_DISPLAY, 5'd0, 32'sd0);
    // fill to capacity, then overflow
    while (occupancy < DEPTH)
      send_action(ACT_INSERT, POS_W'($urandom_range(0, occupancy)),
                  occupancy[0] ? 32'haaaa_aaaa : 32'h5555_5555);
    send_action(ACT_INSERT, 5'd0, 32'sd1);
    send_action(ACT_DISPLAY, 5'd0, 32'sd0);
    // delete last, first and middle entries
    send_action(ACT_DELETE, 5'd15, 32'sd0);
    send_action(ACT_DELETE, 5'd0, 32'sd0);
    send_action(ACT_DELETE, 5'd7, 32'sd0);
    send_action(ACT_CLEAR, 5'd31, 32'hffff_ffff);

    // random phases: slow receiver, then slow sender, then full rate
    repeat (30) send_random();
    tx_idle_pct = 80;
    rx_idle_pct <= 14;
    repeat (30) send_random();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    repeat (30) send_random();
    in_tvalid <= 1'b0;

    // drain, then a short tail to catch stray results
    do @(posedge clk); while (pending_cnt != 0);
    repeat (20) @(posedge clk);
    $display("ran %0d list actions: inserts, deletes, displays and clears", sent);
    $display("compared %0d result transactions, including full-list displays", checked_cnt);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> positional_insert_delete_list.f
+incdir+hdl
hdl/pil_pkg.sv
hdl/pil_cell.sv
hdl/positional_insert_delete_list.sv
dv/pil_list_checker.sv
dv/tb_positional_insert_delete_list.sv
